>>> rtl/core/indexed_list_store_core_assert.svh
// Assertion macros for the indexed list store core.
// Included by the top level; the including module must provide clk and rst.
`ifndef INDEXED_LIST_STORE_CORE_ASSERT_SVH
`define INDEXED_LIST_STORE_CORE_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define ILS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset.
`define ILS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/ils_pkg.sv
// Shared constants and types of the indexed list store core.
// No dependencies; imported by the interfaces, the cell and the top level.
package ils_pkg;

  localparam int CAPACITY = 64;
  localparam int POS_W    = 7;
  localparam int DATA_W   = 32;
  localparam int STAT_W   = 2;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;
  localparam int IDX_W    = $clog2(CAPACITY);

  typedef enum logic [2:0] {
    OP_READ   = 3'd0,
    OP_INSERT = 3'd1,
    OP_HEAD   = 3'd2,
    OP_TAIL   = 3'd3,
    OP_DELETE = 3'd4
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    ST_DONE  = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } stat_t;

  typedef enum logic [1:0] {
    CK_HOLD   = 2'd0,
    CK_INSERT = 2'd1,
    CK_DELETE = 2'd2
  } cell_kind_t;

  // Broadcast to every cell of the chain.
  typedef struct packed {
    cell_kind_t         kind;
    logic [CMP_W-1:0]   pos;
    logic [DATA_W-1:0]  value;
  } cell_ctl_t;

endpackage

>>> rtl/core/ils_if.sv
// Request and response channel interfaces of the indexed list store core.
// Depends on ils_pkg for field widths.
interface ils_req_if;
  import ils_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [2:0]               opcode;
  logic [POS_W-1:0]         position;
  logic signed [DATA_W-1:0] item_value;

  modport source (output valid, output opcode, output position, output item_value,
                  input ready);
  modport sink   (input valid, input opcode, input position, input item_value,
                  output ready);
endinterface

interface ils_rsp_if;
  import ils_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] read_value;
  logic [STAT_W-1:0]        status;
  logic [POS_W-1:0]         entry_count;

  modport source (output valid, output read_value, output status, output entry_count,
                  input ready);
  modport sink   (input valid, input read_value, input status, input entry_count,
                  output ready);
endinterface

>>> rtl/core/ils_cell.sv
// One storage cell of the list chain: holds one entry and shifts with its neighbors.
// Depends on ils_pkg for the control struct.
module ils_cell
  import ils_pkg::*;
(
  input  logic              clk,
  input  cell_ctl_t         ctl,
  input  logic [CMP_W-1:0]  idx,
  input  logic [DATA_W-1:0] lower_entry,
  input  logic [DATA_W-1:0] upper_entry,
  output logic [DATA_W-1:0] entry
);

  // On insert, cells above the position take the entry below them and the cell
  // at the position takes the new value. On delete, cells from the position up
  // take the entry above them.
  always_ff @(posedge clk) begin
    case (ctl.kind)
      CK_INSERT: begin
        if (idx > ctl.pos) begin
          entry <= lower_entry;
        end else if (idx == ctl.pos) begin
          entry <= ctl.value;
        end
      end
      CK_DELETE: begin
        if (idx >= ctl.pos) begin
          entry <= upper_entry;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

>>> rtl/core/indexed_list_store_core.sv
// Top level of the indexed list store core: request decode, count, response register.
// Depends on ils_pkg, ils_if, ils_cell and indexed_list_store_core_assert.svh.
//
// Usage:
//   The req channel carries one request per transfer: opcode, position and
//   item_value. The rsp channel returns exactly one response per request, in
//   order: read_value, status and entry_count (count after the request).
//   Entries live in a chain of CAPACITY cells; an insert or delete shifts all
//   affected cells in the same cycle.
//   The response is registered and is valid in the cycle after request acceptance.
//   Throughput is one request per cycle while the receiver keeps taking
//   responses, set by the cell shift and the response register.
//   The response register can hold a finished response while the next request
//   is accepted in the cycle it is taken; when the receiver stalls, req.ready
//   drops until the held response is taken, and nothing is lost.
//   Reset (rst, synchronous) empties the list and drops any pending response.
//   Cell contents are not cleared; only positions below the count are read.
`include "indexed_list_store_core_assert.svh"

module indexed_list_store_core
  import ils_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  ils_req_if.sink   req,
  ils_rsp_if.source rsp
);

  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  count_next;
  logic [CMP_W-1:0]  count_ext;
  logic [CMP_W-1:0]  pos_ext;
  logic              full;
  logic              in_acc;
  logic              ins_ok;
  logic [DATA_W-1:0] rd_next;
  stat_t             st_next;
  cell_ctl_t         ctl;
  logic [DATA_W-1:0] entries [CAPACITY];

  assign req.ready = !rsp.valid || rsp.ready;
  assign in_acc    = req.valid && req.ready;
  assign count_ext = CMP_W'(count);
  assign pos_ext   = CMP_W'(req.position);
  assign full      = (count == CNT_W'(CAPACITY));

  always_comb begin
    rd_next    = '0;
    st_next    = ST_DONE;
    count_next = count;
    ins_ok     = 1'b0;
    ctl.kind   = CK_HOLD;
    ctl.pos    = pos_ext;
    ctl.value  = req.item_value;
    unique case (op_t'(req.opcode))
      OP_READ: begin
        if (pos_ext < count_ext) begin
          rd_next = entries[pos_ext[IDX_W-1:0]];
        end else begin
          rd_next = '1;
          st_next = ST_RANGE;
        end
      end
      OP_INSERT: begin
        if (pos_ext > count_ext) begin
          st_next = ST_RANGE;
        end else if (full) begin
          st_next = ST_FULL;
        end else begin
          ins_ok = 1'b1;
        end
      end
      OP_HEAD: begin
        ctl.pos = '0;
        if (full) begin
          st_next = ST_FULL;
        end else begin
          ins_ok = 1'b1;
        end
      end
      OP_TAIL: begin
        ctl.pos = count_ext;
        if (full) begin
          st_next = ST_FULL;
        end else begin
          ins_ok = 1'b1;
        end
      end
      OP_DELETE: begin
        if (pos_ext >= count_ext) begin
          st_next = ST_RANGE;
        end else begin
          count_next = count - 1'b1;
          if (in_acc) begin
            ctl.kind = CK_DELETE;
          end
        end
      end
      default: begin
      end
    endcase
    if (ins_ok) begin
      count_next = count + 1'b1;
      if (in_acc) begin
        ctl.kind = CK_INSERT;
      end
    end
  end

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [DATA_W-1:0] lower;
    logic [DATA_W-1:0] upper;
    if (g == 0) begin : g_first
      assign lower = ctl.value;
    end else begin : g_lower
      assign lower = entries[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign upper = entries[g];
    end else begin : g_upper
      assign upper = entries[g+1];
    end
    ils_cell u_cell (
      .clk         (clk),
      .ctl         (ctl),
      .idx         (CMP_W'(g)),
      .lower_entry (lower),
      .upper_entry (upper),
      .entry       (entries[g])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      rsp.valid <= 1'b0;
    end else begin
      if (in_acc) begin
        count           <= count_next;
        rsp.valid       <= 1'b1;
        rsp.read_value  <= rd_next;
        rsp.status      <= st_next;
        rsp.entry_count <= POS_W'(count_next);
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  `ILS_ASSERT_NOW(a_count_bound, 1'b1, count_ext <= CMP_W'(CAPACITY),
    "list count exceeds capacity")
  `ILS_ASSERT_NEXT(a_insert_grows, in_acc && ins_ok,
    count == CNT_W'($past(count) + 1'b1), "successful insert did not grow the list")
  `ILS_ASSERT_NOW(a_full_status, rsp.valid && rsp.status == ST_FULL,
    count == CNT_W'(CAPACITY), "full status reported while list not full")

endmodule
